[src/qcsa_pkg.sv]
// Shared types for the quadrature counter: command and report items.
package qcsa_pkg;

	localparam int unsigned CHAN_FIELD_W = 3;
	localparam int unsigned RPT_W        = 32;

	// opcode values of an input item
	localparam logic OP_EDGE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// classified command handed from the front to the back
	typedef struct packed {
		logic                    tick;
		logic                    up;
		logic [CHAN_FIELD_W-1:0] ch;
	} qcsa_cmd_t;

	// one report item
	typedef struct packed {
		logic [CHAN_FIELD_W-1:0] out_channel;
		logic signed [RPT_W-1:0] position;
		logic signed [RPT_W-1:0] speed;
		logic signed [RPT_W-1:0] acceleration;
		logic                    last;
	} qcsa_rpt_t;

endpackage

[src/quadrature_counter_speed_accel_top.sv]
// Top level of the multi-channel x1 quadrature counter with speed and acceleration.
//
//  channel  | handshake            | fields
//  ---------+----------------------+-----------------------------------------------
//  input    | push / full          | opcode, channel, q2_level
//  report   | pop / empty          | out_channel, position, speed, acceleration, last
//
// Order: the back end applies an edge item to its channel's counter; a tick
//   starts the walk, then gives one report per channel while the report queue
//   has room; the single read port on the per-channel counter registers sets this.
// Reset: arst_n clears all counts, previous counts and previous speeds to zero
//   and empties both queues.
// Stalls: a two-entry command queue parts the front from the back, and a
//   two-entry report queue parts the back from pop, so each side stalls alone.
//   Edges naming an absent channel are dropped in the front.
module quadrature_counter_speed_accel_top
	import qcsa_pkg::*;
#(
	parameter int NUM_CHANNELS = 5,
	parameter int COUNT_WIDTH  = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	output logic                    full,
	input  logic                    opcode,
	input  logic [CHAN_FIELD_W-1:0] channel,
	input  logic                    q2_level,
	output logic                    empty,
	input  logic                    pop,
	output logic [CHAN_FIELD_W-1:0] out_channel,
	output logic signed [RPT_W-1:0] position,
	output logic signed [RPT_W-1:0] speed,
	output logic signed [RPT_W-1:0] acceleration,
	output logic                    last
);

	// front -> command queue
	logic      fe_wr;
	qcsa_cmd_t fe_cmd;
	logic      cq_full;
	// command queue -> back
	qcsa_cmd_t cq_cmd;
	logic      cq_empty;
	logic      cq_rd;
	// back -> report queue
	logic      be_wr;
	qcsa_rpt_t be_rpt;
	logic      rq_full;
	qcsa_rpt_t rq_rpt;

	qcsa_front #(
		.NUM_CHANNELS(NUM_CHANNELS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.opcode  (opcode),
		.channel (channel),
		.q2_level(q2_level),
		.cmd_wr  (fe_wr),
		.cmd_data(fe_cmd),
		.cmd_full(cq_full)
	);

	qcsa_fifo #(
		.T    (qcsa_cmd_t),
		.DEPTH(2)
	) u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (fe_wr),
		.wr_data(fe_cmd),
		.full   (cq_full),
		.rd_en  (cq_rd),
		.rd_data(cq_cmd),
		.empty  (cq_empty)
	);

	qcsa_back #(
		.NUM_CHANNELS(NUM_CHANNELS),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cq_cmd),
		.cmd_empty(cq_empty),
		.cmd_rd   (cq_rd),
		.rpt_wr   (be_wr),
		.rpt      (be_rpt),
		.rpt_full (rq_full)
	);

	// report queue doubles as the output register
	qcsa_fifo #(
		.T    (qcsa_rpt_t),
		.DEPTH(2)
	) u_rptq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (be_wr),
		.wr_data(be_rpt),
		.full   (rq_full),
		.rd_en  (pop),
		.rd_data(rq_rpt),
		.empty  (empty)
	);

	assign out_channel  = rq_rpt.out_channel;
	assign position     = rq_rpt.position;
	assign speed        = rq_rpt.speed;
	assign acceleration = rq_rpt.acceleration;
	assign last         = rq_rpt.last;

	// the back never offers a report into a full queue
	a_rpt_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		be_wr |-> !rq_full)
		else $error("report written into full queue");

	// the back only takes a command that is there
	a_cmd_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		cq_rd |-> !cq_empty)
		else $error("command read from empty queue");

	// the closing report of a walk names the highest channel
	a_last_channel: assert property (@(posedge clk) disable iff (!arst_n)
		(be_wr && be_rpt.last) |-> (be_rpt.out_channel == CHAN_FIELD_W'(NUM_CHANNELS - 1)))
		else $error("last flag on wrong channel");

	// a report is never written while a command is being taken
	a_walk_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		be_wr |-> !cq_rd)
		else $error("command taken during a tick walk");

endmodule

[src/qcsa_fifo.sv]
// Small first-in first-out queue of any packed item type.
module qcsa_fifo
	import qcsa_pkg::*;
#(
	parameter type T     = qcsa_cmd_t,
	parameter int  DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  T     wr_data,
	output logic full,
	input  logic rd_en,
	output T     rd_data,
	output logic empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	T                mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [NW-1:0]   fill_q;
	logic            do_wr;
	logic            do_rd;

	assign full    = (fill_q == NW'(DEPTH));
	assign empty   = (fill_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= ptr_next(wr_ptr_q);
			if (do_rd) rd_ptr_q <= ptr_next(rd_ptr_q);
			if (do_wr && !do_rd) fill_q <= fill_q + 1'b1;
			else if (do_rd && !do_wr) fill_q <= fill_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wr_ptr_q] <= wr_data;
	end

endmodule

[src/qcsa_front.sv]
// Front stage: takes input items, drops edges on absent channels, queues commands.
module qcsa_front
	import qcsa_pkg::*;
#(
	parameter int NUM_CHANNELS = 5
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	output logic                    full,
	input  logic                    opcode,
	input  logic [CHAN_FIELD_W-1:0] channel,
	input  logic                    q2_level,
	output logic                    cmd_wr,
	output qcsa_cmd_t               cmd_data,
	input  logic                    cmd_full
);

	logic      valid_s1;
	qcsa_cmd_t cmd_s1;
	logic      take;
	logic      keep;

	assign cmd_wr   = valid_s1;
	assign cmd_data = cmd_s1;
	assign full     = valid_s1 && cmd_full;
	assign take     = push && !full;
	// edges beyond the channel set change nothing
	assign keep     = (opcode == OP_TICK) || (32'(channel) < NUM_CHANNELS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= keep;
		end else if (!cmd_full) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1.tick <= (opcode == OP_TICK);
			cmd_s1.up   <= q2_level;
			cmd_s1.ch   <= channel;
		end
	end

endmodule

[src/qcsa_back.sv]
// Back end: applies edges to the counters and walks channels on a tick.
module qcsa_back
	import qcsa_pkg::*;
#(
	parameter int NUM_CHANNELS = 5,
	parameter int COUNT_WIDTH  = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  qcsa_cmd_t cmd,
	input  logic      cmd_empty,
	output logic      cmd_rd,
	output logic      rpt_wr,
	output qcsa_rpt_t rpt,
	input  logic      rpt_full
);

	localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	typedef enum logic {
		S_IDLE,
		S_WALK
	} state_t;

	state_t                 state_q;
	logic [CW-1:0]          idx_q;
	logic [COUNT_WIDTH-1:0] cnt_q  [NUM_CHANNELS];
	logic [COUNT_WIDTH-1:0] pcnt_q [NUM_CHANNELS];
	logic [COUNT_WIDTH-1:0] pspd_q [NUM_CHANNELS];

	logic [CW-1:0]          rd_idx;
	logic [COUNT_WIDTH-1:0] cur;
	logic [COUNT_WIDTH-1:0] spd;
	logic [COUNT_WIDTH-1:0] acc;
	logic                   is_last;

	// one read port: the walk index while reporting, else the edge channel
	assign rd_idx  = (state_q == S_WALK) ? idx_q : CW'(cmd.ch);
	assign cur     = cnt_q[rd_idx];
	assign spd     = cur - pcnt_q[rd_idx];
	assign acc     = cur - pcnt_q[rd_idx] - pspd_q[rd_idx];
	assign is_last = (idx_q == CW'(NUM_CHANNELS - 1));

	assign cmd_rd = (state_q == S_IDLE) && !cmd_empty;
	assign rpt_wr = (state_q == S_WALK) && !rpt_full;

	always_comb begin
		rpt.out_channel  = CHAN_FIELD_W'(idx_q);
		rpt.position     = RPT_W'(signed'(cur));
		rpt.speed        = RPT_W'(signed'(spd));
		rpt.acceleration = RPT_W'(signed'(acc));
		rpt.last         = is_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				cnt_q[i]  <= '0;
				pcnt_q[i] <= '0;
				pspd_q[i] <= '0;
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (!cmd_empty) begin
						if (cmd.tick) begin
							idx_q   <= '0;
							state_q <= S_WALK;
						end else if (cmd.up) begin
							cnt_q[rd_idx] <= cur + 1'b1;
						end else begin
							cnt_q[rd_idx] <= cur - 1'b1;
						end
					end
				end
				S_WALK: begin
					if (!rpt_full) begin
						pcnt_q[rd_idx] <= cur;
						pspd_q[rd_idx] <= spd;
						if (is_last) begin
							state_q <= S_IDLE;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
